// ===== sv/imuafp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU angle frame parser package
// Shared types, frame constants and the yaw scaling function.
// ----------------------------------------------------------------------------
package imuafp_pkg;

   localparam logic [7:0]  FRAME_HEAD0    = 8'h55;
   localparam logic [7:0]  FRAME_HEAD1    = 8'h53;
   localparam logic [3:0]  FRAME_LAST     = 4'd10;
   localparam logic [3:0]  YAW_LOW_POS    = 4'd6;
   localparam logic [3:0]  YAW_HIGH_POS   = 4'd7;
   localparam logic [15:0] FRESH_MS_RESET = 16'd100;

   localparam logic signed [26:0] YawScale    = 27'sd1800;
   localparam logic signed [26:0] YawRoundAdj = 27'sd32767;

   localparam logic REQ_BYTE  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef enum logic [1:0] {
      STATUS_NONE = 2'd0,
      STATUS_OK   = 2'd1,
      STATUS_BAD  = 2'd2
   } status_type;

   typedef struct packed {
      logic        req_type;
      logic [7:0]  rx_byte;
      logic [31:0] now_ms;
   } item_type;

   typedef struct packed {
      logic signed [11:0] yaw_tenths;
      logic               yaw_fresh;
      status_type         frame_status;
   } result_type;

   // raw * 1800 / 32768, truncated toward zero
   function automatic logic signed [11:0] scale_yaw(input logic [7:0] high_byte,
                                                    input logic [7:0] low_byte);
      logic signed [15:0] raw;
      logic signed [26:0] prod;
      logic signed [26:0] adj;
      raw  = signed'({high_byte, low_byte});
      prod = 27'(raw) * YawScale;
      adj  = prod[26] ? (prod + YawRoundAdj) : prod;
      return adj[26:15];
   endfunction

endpackage

// ===== sv/imuafp_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU angle frame parser request channel
// Valid/ready channel carrying serial bytes and freshness queries.
// ----------------------------------------------------------------------------
interface imuafp_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [7:0]  rx_byte;
   logic [31:0] now_ms;

   modport source (output valid, req_type, rx_byte, now_ms, input ready);
   modport sink   (input valid, req_type, rx_byte, now_ms, output ready);
endinterface

// ===== sv/imuafp_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU angle frame parser response channel
// Valid/ready channel carrying yaw, freshness and frame status.
// ----------------------------------------------------------------------------
interface imuafp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [11:0] yaw_tenths;
   logic               yaw_fresh;
   logic [1:0]         frame_status;

   modport source (output valid, yaw_tenths, yaw_fresh, frame_status, input ready);
   modport sink   (input valid, yaw_tenths, yaw_fresh, frame_status, output ready);
endinterface

// ===== sv/imuafp_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU angle frame parser core
// Frame hunt state, checksum, stored yaw and freshness of one item.
// ----------------------------------------------------------------------------
module imuafp_parser
   import imuafp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  item_type    item,
   input  logic [15:0] fresh_ms,
   output result_type  result
);

   logic [3:0]         pos_ff,       pos_in;
   logic [7:0]         sum_ff,       sum_in;
   logic [7:0]         low_ff,       low_in;
   logic [7:0]         high_ff,      high_in;
   logic signed [11:0] yaw_ff,       yaw_in;
   logic [31:0]        yaw_time_ff,  yaw_time_in;
   logic               have_yaw_ff,  have_yaw_in;
   status_type         status;
   logic [31:0]        age;
   logic               fresh;

   always_comb begin
      pos_in      = pos_ff;
      sum_in      = sum_ff;
      low_in      = low_ff;
      high_in     = high_ff;
      yaw_in      = yaw_ff;
      yaw_time_in = yaw_time_ff;
      have_yaw_in = have_yaw_ff;
      status      = STATUS_NONE;
      if (item.req_type == REQ_BYTE) begin
         if (pos_ff == 4'd0 || pos_ff > FRAME_LAST) begin
            pos_in = 4'd0;
            if (item.rx_byte == FRAME_HEAD0) begin
               sum_in = item.rx_byte;
               pos_in = 4'd1;
            end
         end else if (pos_ff == 4'd1) begin
            if (item.rx_byte == FRAME_HEAD1) begin
               sum_in = sum_ff + item.rx_byte;
               pos_in = 4'd2;
            end else begin
               pos_in = 4'd0;
            end
         end else if (pos_ff < FRAME_LAST) begin
            if (pos_ff == YAW_LOW_POS) begin
               low_in = item.rx_byte;
            end
            if (pos_ff == YAW_HIGH_POS) begin
               high_in = item.rx_byte;
            end
            sum_in = sum_ff + item.rx_byte;
            pos_in = pos_ff + 4'd1;
         end else begin
            pos_in = 4'd0;
            if (sum_ff == item.rx_byte) begin
               yaw_in      = scale_yaw(high_ff, low_ff);
               yaw_time_in = item.now_ms;
               have_yaw_in = 1'b1;
               status      = STATUS_OK;
            end else begin
               status = STATUS_BAD;
            end
         end
      end
   end

   assign age   = item.now_ms - yaw_time_in;
   assign fresh = have_yaw_in && (age <= {16'd0, fresh_ms});

   assign result.yaw_tenths   = fresh ? yaw_in : 12'sd0;
   assign result.yaw_fresh    = fresh;
   assign result.frame_status = status;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= 4'd0;
         sum_ff      <= 8'd0;
         low_ff      <= 8'd0;
         high_ff     <= 8'd0;
         yaw_ff      <= 12'sd0;
         yaw_time_ff <= 32'd0;
         have_yaw_ff <= 1'b0;
      end else if (step) begin
         pos_ff      <= pos_in;
         sum_ff      <= sum_in;
         low_ff      <= low_in;
         high_ff     <= high_in;
         yaw_ff      <= yaw_in;
         yaw_time_ff <= yaw_time_in;
         have_yaw_ff <= have_yaw_in;
      end
   end

endmodule

// ===== sv/imu_angle_frame_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU angle frame parser
// Hunts serial 0x55 0x53 angle frames, checks the checksum, keeps the latest
// yaw in tenths of a degree with its timestamp and reports its freshness.
//
// req_ch carries one item per transfer: a received serial byte (req_type 0)
// or a freshness query (req_type 1), each with the current time in ms.
// rsp_ch returns exactly one result per item, in order: the yaw (zero when
// not fresh), the fresh flag and the frame status of that byte.
// csr_wr_en / csr_wr_data write fresh_ms; write it only while idle.
// A request is captured in the input register, then its result in the result
// register. Throughput: one item per cycle while rsp_ch is not stalled, set by
// the single pass of parser logic between the two registers.
// Reset clears the frame hunt, drops any stored yaw and sets fresh_ms to 100.
// While rsp_ch is stalled the result register holds; the input register
// still takes one more item, then req_ch.ready falls until the result moves.
// ----------------------------------------------------------------------------
module imu_angle_frame_parser
   import imuafp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   imuafp_req_if.sink      req_ch,
   imuafp_rsp_if.source    rsp_ch,
   input  logic            csr_wr_en,
   input  logic [15:0]     csr_wr_data
);

   logic [15:0] fresh_ms_ff;
   logic        in_valid_ff;
   item_type    in_item_ff;
   logic        out_valid_ff;
   result_type  out_ff;
   result_type  result;
   logic        advance;
   logic        step;

   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign step         = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ms_ff <= FRESH_MS_RESET;
      end else if (csr_wr_en) begin
         fresh_ms_ff <= csr_wr_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_item_ff.req_type <= req_ch.req_type;
         in_item_ff.rx_byte  <= req_ch.rx_byte;
         in_item_ff.now_ms   <= req_ch.now_ms;
      end
   end

   imuafp_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .item     (in_item_ff),
      .fresh_ms (fresh_ms_ff),
      .result   (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= result;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.yaw_tenths   = out_ff.yaw_tenths;
   assign rsp_ch.yaw_fresh    = out_ff.yaw_fresh;
   assign rsp_ch.frame_status = out_ff.frame_status;

endmodule
